[src/rbm_pkg.sv]
package rbm_pkg;

	// Default width of the check and error counters
	localparam int COUNTER_WIDTH_DEF = 32;

	// Event codes carried in the input tuser
	localparam logic [1:0] CMD_PROCESS = 2'd0;
	localparam logic [1:0] CMD_SET     = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// Configuration register indexes
	localparam logic [7:0] CFG_STABILIZATION = 8'd0;
	localparam logic [7:0] CFG_CHECK_INTERVAL = 8'd1;

	// Register reset values
	localparam logic [15:0] STABILIZATION_RST = 16'd10;
	localparam logic [15:0] CHECK_INTERVAL_RST = 16'd100;

	// Beat widths
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] now_ms;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic        drive_level;
		logic        success;
		logic        level_changed;
		logic        error_code;
		logic        confirmed_state;
		logic [31:0] checks_done;
		logic [31:0] errors_seen;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

[src/rbm_in_reg.sv]
module rbm_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rbm_pkg::in_item_t  in_item,
	input  logic               advance,
	output logic               valid_s1,
	output rbm_pkg::in_item_t  item_s1
);

	// Take a new beat when empty or when the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[src/rbm_core.sv]
module rbm_core #(
	parameter int COUNTER_WIDTH = rbm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rbm_pkg::cfg_wr_t   cfg_wr,
	input  logic               advance,
	input  rbm_pkg::in_item_t  item_s1,
	output rbm_pkg::result_t   result
);

	logic [15:0] stabilization_q;
	logic [15:0] check_interval_q;

	logic                     target_high_q, target_high_n;
	logic                     confirmed_q, confirmed_n;
	logic                     first_pending_q, first_pending_n;
	logic [31:0]              clear_stamp_q, clear_stamp_n;
	logic [31:0]              last_check_q, last_check_n;
	logic [COUNTER_WIDTH-1:0] check_total_q, check_total_n;
	logic [COUNTER_WIDTH-1:0] error_total_q, error_total_n;

	logic [31:0] since_clear;
	logic [31:0] since_check;
	logic        check_due;
	logic        success;
	logic        changed;
	logic        err;
	logic [63:0] checks_ext;
	logic [63:0] errors_ext;

	assign since_clear = item_s1.now_ms - clear_stamp_q;
	assign since_check = item_s1.now_ms - last_check_q;

	// Evaluate one event against the current state
	always_comb begin
		target_high_n   = target_high_q;
		confirmed_n     = confirmed_q;
		first_pending_n = first_pending_q;
		clear_stamp_n   = clear_stamp_q;
		last_check_n    = last_check_q;
		check_total_n   = check_total_q;
		error_total_n   = error_total_q;
		check_due       = 1'b0;
		success         = 1'b0;
		changed         = 1'b0;
		err             = 1'b0;
		case (item_s1.cmd)
			rbm_pkg::CMD_SET: begin
				changed         = !item_s1.pin_level;
				target_high_n   = 1'b1;
				confirmed_n     = 1'b1;
				first_pending_n = 1'b0;
				last_check_n    = '0;
				success         = 1'b1;
			end
			rbm_pkg::CMD_CLEAR: begin
				changed         = item_s1.pin_level;
				target_high_n   = 1'b0;
				confirmed_n     = 1'b0;
				clear_stamp_n   = item_s1.now_ms;
				first_pending_n = 1'b1;
				last_check_n    = '0;
				success         = 1'b1;
			end
			rbm_pkg::CMD_PROCESS: begin
				if (!target_high_q) begin
					if (first_pending_q) begin
						check_due = since_clear >= {16'd0, stabilization_q};
					end else begin
						check_due = since_check >= {16'd0, check_interval_q};
					end
				end
			end
			default: ;
		endcase

		// Readback check: count it, and count or clear the failure
		if (check_due) begin
			if (check_total_q != '1) begin
				check_total_n = check_total_q + COUNTER_WIDTH'(1);
			end
			if (item_s1.pin_level) begin
				err = 1'b1;
				if (error_total_q != '1) begin
					error_total_n = error_total_q + COUNTER_WIDTH'(1);
				end
			end else begin
				first_pending_n = 1'b0;
				last_check_n    = item_s1.now_ms;
				confirmed_n     = 1'b0;
			end
		end
	end

	assign checks_ext = 64'(check_total_n);
	assign errors_ext = 64'(error_total_n);

	// Result fields follow the updated state
	always_comb begin
		result.drive_level     = target_high_n;
		result.success         = success;
		result.level_changed   = changed;
		result.error_code      = err;
		result.confirmed_state = confirmed_n;
		result.checks_done     = checks_ext[31:0];
		result.errors_seen     = errors_ext[31:0];
	end

	// Configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stabilization_q  <= rbm_pkg::STABILIZATION_RST;
			check_interval_q <= rbm_pkg::CHECK_INTERVAL_RST;
		end else if (cfg_wr.valid) begin
			if (cfg_wr.index == rbm_pkg::CFG_STABILIZATION) begin
				stabilization_q <= cfg_wr.data;
			end else if (cfg_wr.index == rbm_pkg::CFG_CHECK_INTERVAL) begin
				check_interval_q <= cfg_wr.data;
			end
		end
	end

	// Advance the monitor state once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_high_q   <= 1'b0;
			confirmed_q     <= 1'b0;
			first_pending_q <= 1'b0;
			clear_stamp_q   <= '0;
			last_check_q    <= '0;
			check_total_q   <= '0;
			error_total_q   <= '0;
		end else if (advance) begin
			target_high_q   <= target_high_n;
			confirmed_q     <= confirmed_n;
			first_pending_q <= first_pending_n;
			clear_stamp_q   <= clear_stamp_n;
			last_check_q    <= last_check_n;
			check_total_q   <= check_total_n;
			error_total_q   <= error_total_n;
		end
	end

endmodule

[src/rbm_out_reg.sv]
module rbm_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rbm_pkg::result_t  result,
	output logic              load_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output rbm_pkg::result_t  out_result
);

	// Free when empty or when the held beat leaves now
	assign load_ok = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_ok) begin
			out_valid <= load;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_result <= result;
		end
	end

endmodule

[src/safety_output_readback_monitor.sv]
// An accepted input beat is held in the input register, its result beat in the result
// register on the master side. Throughput: one event per cycle while m_tready allows;
// each event is evaluated combinationally between the input and result registers.
// Reset (arst_n low, asynchronous): both sides empty, line driven low, no check
// pending, stamps and counters zero, registers at stabilization 10 ms, interval 100 ms.
module safety_output_readback_monitor #(
	parameter int COUNTER_WIDTH = rbm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rbm_pkg::IN_TDATA_W-1:0]   s_tdata,  // now_ms[31:0], pin_level, zero pad
	input  logic [1:0]                       s_tuser,  // cmd[1:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// drive_level, success, level_changed, error_code, confirmed_state,
	// checks_done[31:0], errors_seen[31:0], zero pad
	output logic [rbm_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [7:0]                       cfg_index,
	input  logic [15:0]                      cfg_data
);

	rbm_pkg::in_item_t in_item;
	rbm_pkg::in_item_t item_s1;
	rbm_pkg::result_t  result;
	rbm_pkg::result_t  out_result;
	rbm_pkg::cfg_wr_t  cfg_wr;
	logic              valid_s1;
	logic              load_ok;
	logic              advance;

	// Unpack the input beat
	assign in_item.cmd       = s_tuser;
	assign in_item.now_ms    = s_tdata[31:0];
	assign in_item.pin_level = s_tdata[32];

	// Configuration writes are always taken
	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign advance = valid_s1 && load_ok;

	rbm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rbm_core #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	rbm_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.result     (result),
		.load_ok    (load_ok),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	// Pack the result beat
	assign m_tdata = {3'b000,
		out_result.errors_seen,
		out_result.checks_done,
		out_result.confirmed_state,
		out_result.error_code,
		out_result.level_changed,
		out_result.success,
		out_result.drive_level};

	// An accepted input beat lands in the input register
	a_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted input beat not registered");

	// An evaluated event always produces a result beat
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("evaluated event produced no result");

	// A set event drives the line high in its result
	a_set_drives: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == rbm_pkg::CMD_SET |=> m_tvalid && m_tdata[0] && m_tdata[1])
		else $error("set event did not drive line high");

	// A failed check only happens while the line is driven low
	a_err_low: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.error_code |=> !m_tdata[0] && !m_tdata[1])
		else $error("readback error reported while driven high");

endmodule
